// ===== src/fafs_pkg.sv =====
// shared types and codes for the frame atomic sample fifo
`timescale 1ns / 1ps
`default_nettype none

package fafs_pkg;

  localparam int WORD_W = 32;
  localparam int LEN_W  = 10;
  localparam int CNT_W  = 7;
  localparam int KIND_W = 2;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [WORD_W-1:0] word;
    logic              accepted;
    logic [CNT_W-1:0]  count;
    logic              last;
  } result_t;

endpackage

`default_nettype wire

// ===== src/fafs_ram.sv =====
// generic simple dual port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module fafs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire                     clk,
  input  wire                     wr_en,
  input  wire [$clog2(DEPTH)-1:0] wr_addr,
  input  wire [WIDTH-1:0]         wr_data,
  input  wire                     rd_en,
  input  wire [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // output holds while rd_en is low
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== src/frame_atomic_sample_fifo.sv =====
// top level of the frame atomic sample fifo
`timescale 1ns / 1ps
`default_nettype none

// channel  dir  tdata (low bit up)                          tuser   tlast
// s_*      in   sample_word[31:0] frame_len[41:32]          mode    -
//               max_count[48:42] zero pad[55:49]
// m_*      out  popped_word[31:0] accepted[32]              kind    last
//               pop_count[39:33]
//
// a push sample is written straight into the sample ram unless its frame is dropped
// a pop is accepted, then streams one sample per cycle through the registered
// ram read port while the output is not held by m_tready
// an empty pop or a frame status is loaded into the output register on accept
// synchronous reset clears pointers and frame state; the ram is not cleared
// requests wait while a pop drains; m_tready low holds the ram output and
// the output register, nothing is lost

module frame_atomic_sample_fifo #(
  parameter int DEPTH       = 1024,
  parameter int SAMPLE_BITS = 32,
  parameter int MAX_POP     = 64
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [55:0] s_tdata,   // sample_word, frame_len, max_count, pad
  input  wire         s_tuser,   // mode
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [39:0] m_tdata,   // popped_word, accepted, pop_count
  output logic [1:0]  m_tuser,   // kind
  output logic        m_tlast
);

  localparam int AW = $clog2(DEPTH);
  localparam int PW = AW + 1;
  localparam int SW = ((PW > fafs_pkg::LEN_W) ? PW : fafs_pkg::LEN_W) + 1;
  localparam int CW = (PW > fafs_pkg::CNT_W) ? PW : fafs_pkg::CNT_W;
  localparam logic [SW-1:0] ROOM = SW'(DEPTH - 1);
  localparam logic [PW-1:0] PTR_FULL = PW'(DEPTH - 1);
  localparam logic [fafs_pkg::CNT_W-1:0] POP_LIM = fafs_pkg::CNT_W'(MAX_POP);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_POP  = 1'b1;

  // request fields
  logic                         in_mode;
  logic [fafs_pkg::WORD_W-1:0]  in_word;
  logic [fafs_pkg::LEN_W-1:0]   in_len;
  logic [fafs_pkg::CNT_W-1:0]   in_max;

  assign in_mode = s_tuser;
  assign in_word = s_tdata[31:0];
  assign in_len  = s_tdata[41:32];
  assign in_max  = s_tdata[48:42];

  // control state
  logic                        state, state_next;
  logic [PW-1:0]               rp, rp_next;
  logic [PW-1:0]               cwp, cwp_next;
  logic [PW-1:0]               pwp, pwp_next;
  logic [fafs_pkg::LEN_W-1:0]  frame_rem, frame_rem_next;
  logic                        dropping, dropping_next;
  logic [fafs_pkg::CNT_W-1:0]  issue_left, issue_left_next;
  logic [fafs_pkg::CNT_W-1:0]  load_left, load_left_next;
  logic [fafs_pkg::CNT_W-1:0]  cnt, cnt_next;
  logic [AW-1:0]               rd_addr, rd_addr_next;
  logic                        rd_pend, rd_pend_next;
  logic                        m_tvalid_next;
  fafs_pkg::result_t           res_q, res;
  logic                        res_load;

  // ram ports
  logic                        wr_en;
  logic [AW-1:0]               wr_addr;
  logic [SAMPLE_BITS-1:0]      wr_data;
  logic                        rd_en;
  logic [SAMPLE_BITS-1:0]      rd_data;
  logic [63:0]                 rd_wide;

  logic out_free;
  logic accept;
  logic load;

  assign out_free = !m_tvalid || m_tready;
  // a new request only while no pop is draining and the output can take a result
  assign s_tready = (state == ST_IDLE) && out_free;
  assign accept   = s_tvalid && s_tready;

  // ram output moves to the output register when that register frees up
  assign load  = rd_pend && out_free;
  // keep one read in flight ahead of the output register
  assign rd_en = (issue_left != '0) && (!rd_pend || load);

  assign rd_wide = 64'(rd_data);
  assign wr_data = SAMPLE_BITS'(in_word);

  fafs_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    logic                        first;
    logic [PW-1:0]               occ;
    logic [SW-1:0]               room_sum;
    logic                        drop;
    logic [PW-1:0]               base;
    logic [PW-1:0]               base_inc;
    logic [fafs_pkg::LEN_W-1:0]  rem_cur;
    logic [fafs_pkg::LEN_W-1:0]  rem_dec;
    logic [fafs_pkg::CNT_W-1:0]  lim;
    logic [fafs_pkg::CNT_W-1:0]  avail;

    first    = (frame_rem == '0);
    occ      = cwp - rp;
    room_sum = SW'(occ) + SW'(in_len);
    // room is judged once, on the opening sample of a frame
    drop     = first ? (room_sum > ROOM) : dropping;
    base     = first ? cwp : pwp;
    base_inc = base + PW'(1);
    rem_cur  = first ? in_len : frame_rem;
    rem_dec  = rem_cur - fafs_pkg::LEN_W'(1);
    lim      = (in_max > POP_LIM) ? POP_LIM : in_max;
    avail    = (CW'(occ) > CW'(lim)) ? lim : fafs_pkg::CNT_W'(occ);

    state_next      = state;
    rp_next         = rp;
    cwp_next        = cwp;
    pwp_next        = pwp;
    frame_rem_next  = frame_rem;
    dropping_next   = dropping;
    issue_left_next = issue_left;
    load_left_next  = load_left;
    cnt_next        = cnt;
    rd_addr_next    = rd_addr;
    rd_pend_next    = rd_en || (rd_pend && !load);
    wr_en           = 1'b0;
    wr_addr         = base[AW-1:0];
    res_load        = 1'b0;
    res             = '0;

    if (accept) begin
      if (in_mode == fafs_pkg::MODE_PUSH) begin
        if (first && (in_len == '0)) begin
          // empty frame always fits
          res_load     = 1'b1;
          res.kind     = fafs_pkg::KIND_STATUS;
          res.accepted = 1'b1;
          res.last     = 1'b1;
        end else begin
          frame_rem_next = rem_dec;
          if (!drop) begin
            wr_en    = 1'b1;
            pwp_next = base_inc;
          end else begin
            pwp_next = base;
          end
          if (rem_dec == '0) begin
            // frame closes: commit or report the drop
            res_load      = 1'b1;
            res.kind      = fafs_pkg::KIND_STATUS;
            res.accepted  = !drop;
            res.last      = 1'b1;
            dropping_next = 1'b0;
            if (!drop) begin
              cwp_next = base_inc;
            end
          end else begin
            dropping_next = drop;
          end
        end
      end else begin
        if (avail == '0) begin
          res_load = 1'b1;
          res.kind = fafs_pkg::KIND_EMPTY;
          res.last = 1'b1;
        end else begin
          state_next      = ST_POP;
          load_left_next  = avail;
          issue_left_next = avail;
          cnt_next        = avail;
          rd_addr_next    = rp[AW-1:0];
          rp_next         = PW'(CW'(rp) + CW'(avail));
        end
      end
    end

    if (rd_en) begin
      rd_addr_next    = rd_addr + AW'(1);
      issue_left_next = issue_left - fafs_pkg::CNT_W'(1);
    end

    if (load) begin
      res_load       = 1'b1;
      res.kind       = fafs_pkg::KIND_SAMPLE;
      res.word       = rd_wide[31:0];
      res.count      = cnt;
      res.last       = (load_left == fafs_pkg::CNT_W'(1));
      load_left_next = load_left - fafs_pkg::CNT_W'(1);
      if (load_left == fafs_pkg::CNT_W'(1)) begin
        state_next = ST_IDLE;
      end
    end

    m_tvalid_next = res_load ? 1'b1 : (m_tready ? 1'b0 : m_tvalid);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      rp         <= '0;
      cwp        <= '0;
      pwp        <= '0;
      frame_rem  <= '0;
      dropping   <= 1'b0;
      issue_left <= '0;
      load_left  <= '0;
      rd_pend    <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      state      <= state_next;
      rp         <= rp_next;
      cwp        <= cwp_next;
      pwp        <= pwp_next;
      frame_rem  <= frame_rem_next;
      dropping   <= dropping_next;
      issue_left <= issue_left_next;
      load_left  <= load_left_next;
      rd_pend    <= rd_pend_next;
      m_tvalid   <= m_tvalid_next;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    cnt     <= cnt_next;
    rd_addr <= rd_addr_next;
    if (res_load) begin
      res_q <= res;
    end
  end

  assign m_tdata = {res_q.count, res_q.accepted, res_q.word};
  assign m_tuser = res_q.kind;
  assign m_tlast = res_q.last;

  // committed occupancy never exceeds the usable slots
  a_occ: assert property (@(posedge clk) disable iff (rst)
    PW'(cwp - rp) <= PTR_FULL)
    else $error("committed occupancy over capacity");

  // an open stored frame never overruns unread samples
  a_pend: assert property (@(posedge clk) disable iff (rst)
    (frame_rem != '0) && !dropping |-> PW'(pwp - rp) <= PTR_FULL)
    else $error("pending frame overruns read pointer");

  // ram output only pending while a pop drains
  a_rd: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> (state == ST_POP))
    else $error("read pending outside pop");

  // reads issued never outrun results delivered by more than one
  a_issue: assert property (@(posedge clk) disable iff (rst)
    (issue_left <= load_left) && ((load_left - issue_left) <= fafs_pkg::CNT_W'(1)))
    else $error("pop read accounting broken");

endmodule

`default_nettype wire
